>>> hw/rtl/krt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package krt_pkg;

  localparam int unsigned Entries    = 128;
  localparam int unsigned CntW       = $clog2(Entries + 1);
  localparam int unsigned KeyBytes   = 16;
  localparam int unsigned PhoneBytes = 16;
  localparam int unsigned MailBytes  = 32;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_LOOKUP = 2'd1,
    OP_CHANGE = 2'd2,
    OP_DELETE = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_ADDED    = 3'd0,
    ST_FULL     = 3'd1,
    ST_FOUND    = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_UPDATED  = 3'd4,
    ST_DELETED  = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_RUN,
    FSM_OUT
  } fsm_e;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [63:0] key_hi;
    logic [63:0] key_lo;
    logic [63:0] phone_hi;
    logic [63:0] phone_lo;
    logic [63:0] mail_w0;
    logic [63:0] mail_w1;
    logic [63:0] mail_w2;
    logic [63:0] mail_w3;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  entries_now;
    logic [63:0] found_phone_hi;
    logic [63:0] found_phone_lo;
    logic [63:0] found_mail_w0;
    logic [63:0] found_mail_w1;
    logic [63:0] found_mail_w2;
    logic [63:0] found_mail_w3;
  } rsp_t;

  typedef struct packed {
    logic [127:0] key;
    logic [127:0] phone;
    logic [255:0] mail;
  } rec_t;

  function automatic logic [127:0] canon2(input logic [127:0] w, input int unsigned lim);
    logic [127:0] r;
    logic         ended;
    r = w;
    ended = 1'b0;
    for (int i = 0; i < 16; i++) begin
      if (ended || i >= lim || w[127-8*i -: 8] == 8'd0) begin
        ended = 1'b1;
        r[127-8*i -: 8] = 8'd0;
      end
    end
    return r;
  endfunction

  function automatic logic [255:0] canon4(input logic [255:0] w, input int unsigned lim);
    logic [255:0] r;
    logic         ended;
    r = w;
    ended = 1'b0;
    for (int i = 0; i < 32; i++) begin
      if (ended || i >= lim || w[255-8*i -: 8] == 8'd0) begin
        ended = 1'b1;
        r[255-8*i -: 8] = 8'd0;
      end
    end
    return r;
  endfunction

endpackage
`default_nettype wire

>>> hw/rtl/krt_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// One record slot of the circular chain; head cell 0 is compared each cycle while the ring rotates.
module krt_cell (
  input  wire logic              clk_i,
  input  wire logic              rotate_i,
  input  wire logic              load_i,
  input  wire krt_pkg::rec_t     nbr_i,
  input  wire krt_pkg::rec_t     load_rec_i,
  output krt_pkg::rec_t          rec_o
);
  krt_pkg::rec_t rec_q, rec_d;

  always_comb begin
    rec_d = rec_q;
    if (load_i) begin
      rec_d = load_rec_i;
    end else if (rotate_i) begin
      rec_d = nbr_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rec_q <= rec_d;
  end

  assign rec_o = rec_q;
endmodule
`default_nettype wire

>>> hw/rtl/keyed_record_table_top.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel  | valid / ready        | word
// request  | req_valid_i/_ready_o | req_i  (krt_pkg::req_t)
// response | rsp_valid_o/_ready_i | rsp_o  (krt_pkg::rsp_t)
//
// Records sit in a ring of Entries cells. Lookup, change and delete rotate the
// ring one full turn so every record passes cell 0, where the key compare and
// payload rewrite happen; then the result word is offered. Add goes straight
// to the result. It is held while rsp_ready_i is low, and the next request is
// accepted only after the result has been taken.
// Reset clears only the record count and control; cell contents stay unknown.
// Delete marks the matching index during the turn, then each cell from that
// index on takes its upper neighbor so survivors stay in order.
module keyed_record_table_top (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          req_valid_i,
  output logic               req_ready_o,
  input  wire krt_pkg::req_t req_i,
  output logic               rsp_valid_o,
  input  wire logic          rsp_ready_i,
  output krt_pkg::rsp_t      rsp_o
);
  localparam int unsigned N  = krt_pkg::Entries;
  localparam int unsigned IW = $clog2(N);
  localparam int unsigned CW = krt_pkg::CntW;

  krt_pkg::fsm_e state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] step_q, step_d;
  logic          hit_q, hit_d;
  logic [1:0]    op_q;
  logic [127:0]  key_q, phone_q;
  logic [255:0]  mail_q;
  krt_pkg::rsp_t rsp_q, rsp_d;

  krt_pkg::rec_t cell_rec [N];
  krt_pkg::rec_t nbr_rec [N];
  krt_pkg::rec_t load_rec [N];
  logic          cell_load [N];
  logic          rotate;
  krt_pkg::rec_t head;
  krt_pkg::rec_t req_rec;
  logic          head_live, head_match, act;

  // Canonical form of the incoming word: drop every byte after the terminator.
  assign req_rec.key   = krt_pkg::canon2({req_i.key_hi, req_i.key_lo}, krt_pkg::KeyBytes);
  assign req_rec.phone = krt_pkg::canon2({req_i.phone_hi, req_i.phone_lo},
                                         krt_pkg::PhoneBytes);
  assign req_rec.mail  = krt_pkg::canon4({req_i.mail_w0, req_i.mail_w1,
                                          req_i.mail_w2, req_i.mail_w3},
                                         krt_pkg::MailBytes);

  // Ring: cell i takes cell i+1, last takes cell 0 (head) or a modified head.
  assign head       = cell_rec[0];
  assign head_live  = (step_q < count_q);
  assign head_match = head_live && !hit_q && (head.key == key_q);
  assign act        = head_match && (op_q != krt_pkg::OP_LOOKUP);

  // Rotation brings the head back into the last cell; a change rewrites the
  // payload on the way.
  logic          del_skip_q, del_skip_d;
  krt_pkg::rec_t tail_in;

  always_comb begin
    tail_in = head;
    if (act && op_q == krt_pkg::OP_CHANGE) begin
      tail_in.phone = phone_q;
      tail_in.mail  = mail_q;
    end
  end

  genvar g;
  generate
    for (g = 0; g < N; g++) begin : g_cell
      if (g == N - 1) begin : g_last
        assign nbr_rec[g] = tail_in;
      end else begin : g_mid
        assign nbr_rec[g] = cell_rec[g+1];
      end
      krt_cell u_cell (
        .clk_i      (clk_i),
        .rotate_i   (rotate),
        .load_i     (cell_load[g]),
        .nbr_i      (nbr_rec[g]),
        .load_rec_i (load_rec[g]),
        .rec_o      (cell_rec[g])
      );
    end
  endgenerate

  // Add writes the cell at count_q; after a full turn, delete shifts every
  // cell from the matched index on down by one, the freed tail keeps junk.
  logic [IW-1:0] del_idx_q, del_idx_d;
  logic          shift_down;

  always_comb begin
    for (int i = 0; i < N; i++) begin
      cell_load[i] = 1'b0;
      load_rec[i]  = cell_rec[i];
      if (state_q == krt_pkg::FSM_IDLE && req_valid_i &&
          req_i.opcode == krt_pkg::OP_ADD && count_q < CW'(N) &&
          count_q[IW-1:0] == IW'(i)) begin
        cell_load[i] = 1'b1;
        load_rec[i]  = req_rec;
      end
      if (shift_down && IW'(i) >= del_idx_q && i != N - 1) begin
        cell_load[i] = 1'b1;
        load_rec[i]  = nbr_rec[i];
      end
    end
  end

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    step_d     = step_q;
    hit_d      = hit_q;
    del_idx_d  = del_idx_q;
    del_skip_d = del_skip_q;
    rsp_d      = rsp_q;
    rotate     = 1'b0;
    shift_down = 1'b0;
    unique case (state_q)
      krt_pkg::FSM_IDLE: begin
        if (req_valid_i) begin
          step_d     = '0;
          hit_d      = 1'b0;
          del_skip_d = 1'b0;
          rsp_d      = '0;
          if (req_i.opcode == krt_pkg::OP_ADD) begin
            if (count_q < CW'(N)) begin
              count_d      = count_q + 1'b1;
              rsp_d.status = krt_pkg::ST_ADDED;
            end else begin
              rsp_d.status = krt_pkg::ST_FULL;
            end
            rsp_d.entries_now = 8'(count_d);
            state_d = krt_pkg::FSM_OUT;
          end else begin
            state_d = krt_pkg::FSM_RUN;
          end
        end
      end
      krt_pkg::FSM_RUN: begin
        if (del_skip_q) begin
          // close the gap in place
          shift_down = 1'b1;
          count_d    = count_q - 1'b1;
          rsp_d.status      = krt_pkg::ST_DELETED;
          rsp_d.entries_now = 8'(count_q - 1'b1);
          state_d    = krt_pkg::FSM_OUT;
        end else begin
          rotate = 1'b1;
          step_d = step_q + 1'b1;
          if (head_match) begin
            hit_d     = 1'b1;
            del_idx_d = step_q[IW-1:0];
            if (op_q == krt_pkg::OP_LOOKUP) begin
              {rsp_d.found_phone_hi, rsp_d.found_phone_lo} = head.phone;
              {rsp_d.found_mail_w0, rsp_d.found_mail_w1,
               rsp_d.found_mail_w2, rsp_d.found_mail_w3} = head.mail;
            end
          end
          if (step_q == CW'(N - 1)) begin
            rsp_d.entries_now = 8'(count_q);
            if (!(hit_q || head_match)) begin
              rsp_d.status = krt_pkg::ST_NOTFOUND;
              state_d      = krt_pkg::FSM_OUT;
            end else if (op_q == krt_pkg::OP_LOOKUP) begin
              rsp_d.status = krt_pkg::ST_FOUND;
              state_d      = krt_pkg::FSM_OUT;
            end else if (op_q == krt_pkg::OP_CHANGE) begin
              rsp_d.status = krt_pkg::ST_UPDATED;
              state_d      = krt_pkg::FSM_OUT;
            end else begin
              del_skip_d = 1'b1;
            end
          end
        end
      end
      krt_pkg::FSM_OUT: begin
        if (rsp_ready_i) begin
          state_d = krt_pkg::FSM_IDLE;
        end
      end
      default: state_d = krt_pkg::FSM_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= krt_pkg::FSM_IDLE;
      count_q    <= '0;
      step_q     <= '0;
      hit_q      <= 1'b0;
      del_skip_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      count_q    <= count_d;
      step_q     <= step_d;
      hit_q      <= hit_d;
      del_skip_q <= del_skip_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rsp_q     <= rsp_d;
    del_idx_q <= del_idx_d;
    if (state_q == krt_pkg::FSM_IDLE && req_valid_i) begin
      op_q    <= req_i.opcode;
      key_q   <= req_rec.key;
      phone_q <= req_rec.phone;
      mail_q  <= req_rec.mail;
    end
  end

  assign req_ready_o = (state_q == krt_pkg::FSM_IDLE);
  assign rsp_valid_o = (state_q == krt_pkg::FSM_OUT);
  assign rsp_o       = rsp_q;
endmodule
`default_nettype wire

>>> bench/keyed_record_table_top_tb.sv
`timescale 1ns / 1ps
module keyed_record_table_top_tb;

  localparam int unsigned TableDepth = 128;
  localparam int unsigned CycleLimit = 3000000;

  logic           clk = 1'b0;
  logic           rst_n = 1'b0;
  logic           req_valid = 1'b0;
  logic           req_ready;
  krt_pkg::req_t  req_word = '0;
  logic           rsp_valid;
  logic           rsp_ready = 1'b0;
  krt_pkg::rsp_t  rsp_word;

  keyed_record_table_top i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .req_valid_i (req_valid),
    .req_ready_o (req_ready),
    .req_i       (req_word),
    .rsp_valid_o (rsp_valid),
    .rsp_ready_i (rsp_ready),
    .rsp_o       (rsp_word)
  );

  always #1 clk = ~clk;

  // Shadow copy of the table, kept in canonical form.
  logic [127:0] shadow_key   [TableDepth];
  logic [127:0] shadow_phone [TableDepth];
  logic [255:0] shadow_mail  [TableDepth];
  int unsigned  shadow_count;

  krt_pkg::rsp_t pending_rsp [$];
  int unsigned  fail_count;
  int unsigned  rsp_count;
  int unsigned  status_hits [6];
  int unsigned  send_idle_pct;
  int unsigned  recv_stall_pct;
  int unsigned  hold_off_cycles;
  longint unsigned cycle_count;

  // Zero every byte from the first zero byte on, and every byte past lim.
  function automatic logic [255:0] trim_text(input logic [255:0] w, input int unsigned nbytes,
                                             input int unsigned lim);
    logic [255:0] r;
    logic         ended;
    int unsigned  sh;
    r = w;
    ended = 1'b0;
    for (int i = 0; i < nbytes; i++) begin
      sh = 8 * (nbytes - 1 - i);
      if (ended || i >= lim || r[sh +: 8] == 8'd0) begin
        ended = 1'b1;
        r[sh +: 8] = 8'd0;
      end
    end
    return r;
  endfunction

  // Apply one request to the shadow table and return the expected response.
  function automatic krt_pkg::rsp_t apply_request(input krt_pkg::req_t rq);
    krt_pkg::rsp_t rs;
    logic [127:0] k;
    logic [127:0] ph;
    logic [255:0] ml;
    int           hit;
    rs  = '0;
    k   = 128'(trim_text({128'd0, rq.key_hi, rq.key_lo}, 16, krt_pkg::KeyBytes));
    ph  = 128'(trim_text({128'd0, rq.phone_hi, rq.phone_lo}, 16, krt_pkg::PhoneBytes));
    ml  = trim_text({rq.mail_w0, rq.mail_w1, rq.mail_w2, rq.mail_w3}, 32,
                    krt_pkg::MailBytes);
    hit = -1;
    for (int i = 0; i < shadow_count; i++) begin
      if (hit < 0 && shadow_key[i] == k) hit = i;
    end
    if (krt_pkg::op_e'(rq.opcode) == krt_pkg::OP_ADD) begin
      if (shadow_count < TableDepth) begin
        shadow_key[shadow_count]   = k;
        shadow_phone[shadow_count] = ph;
        shadow_mail[shadow_count]  = ml;
        shadow_count++;
        rs.status = krt_pkg::ST_ADDED;
      end else begin
        rs.status = krt_pkg::ST_FULL;
      end
    end else if (hit < 0) begin
      rs.status = krt_pkg::ST_NOTFOUND;
    end else begin
      case (krt_pkg::op_e'(rq.opcode))
        krt_pkg::OP_LOOKUP: begin
          {rs.found_phone_hi, rs.found_phone_lo} = shadow_phone[hit];
          {rs.found_mail_w0, rs.found_mail_w1, rs.found_mail_w2, rs.found_mail_w3} =
            shadow_mail[hit];
          rs.status = krt_pkg::ST_FOUND;
        end
        krt_pkg::OP_CHANGE: begin
          shadow_phone[hit] = ph;
          shadow_mail[hit]  = ml;
          rs.status = krt_pkg::ST_UPDATED;
        end
        default: begin
          for (int j = hit; j + 1 < shadow_count; j++) begin
            shadow_key[j]   = shadow_key[j+1];
            shadow_phone[j] = shadow_phone[j+1];
            shadow_mail[j]  = shadow_mail[j+1];
          end
          shadow_count--;
          rs.status = krt_pkg::ST_DELETED;
        end
      endcase
    end
    rs.entries_now = shadow_count[7:0];
    return rs;
  endfunction

  // Offer one word, hold it until taken, then idle at the current rate.
  task automatic send_request(input krt_pkg::req_t rq, input logic pinned,
                              input krt_pkg::rsp_t pinned_rsp);
    krt_pkg::rsp_t predicted;
    req_valid <= 1'b1;
    req_word  <= rq;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    predicted = apply_request(rq);
    if (pinned && predicted != pinned_rsp) begin
      $error("directed row disagrees with shadow table: %h vs %h", pinned_rsp, predicted);
      fail_count++;
    end
    pending_rsp.push_back(predicted);
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic drain_responses();
    req_valid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
  endtask

  function automatic logic [63:0] rand_word();
    return {$urandom(), $urandom()};
  endfunction

  // Short text: usually first two bytes nonzero, rest zero, sometimes raw noise.
  function automatic logic [127:0] rand_key(input int unsigned pool);
    case ($urandom_range(9))
      0: return {rand_word(), rand_word()};
      1: return {rand_word(), 64'd0};
      default: return {8'h41 + 8'($urandom_range(pool - 1)), 8'h7a, 112'd0};
    endcase
  endfunction

  function automatic krt_pkg::req_t rand_request(input int unsigned pool);
    krt_pkg::req_t rq;
    rq = '0;
    {rq.key_hi, rq.key_lo} = rand_key(pool);
    // Stray bytes past a terminator must be ignored by the compare.
    if ($urandom_range(3) == 0) rq.key_lo[7:0] = 8'($urandom());
    {rq.phone_hi, rq.phone_lo} = {rand_word(), rand_word()};
    {rq.mail_w0, rq.mail_w1, rq.mail_w2, rq.mail_w3} =
      {rand_word(), rand_word(), rand_word(), rand_word()};
    rq.opcode = 2'($urandom_range(3));
    return rq;
  endfunction

  // Response checker: compare each taken word against the oldest prediction.
  always @(posedge clk) begin
    krt_pkg::rsp_t want;
    if (rst_n && rsp_valid && rsp_ready) begin
      if (pending_rsp.size() == 0) begin
        $error("response with nothing outstanding: %h", rsp_word);
        fail_count++;
      end else begin
        want = pending_rsp.pop_front();
        rsp_count++;
        if (want.status < 6) status_hits[want.status]++;
        if (rsp_word.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, rsp_word.status);
          fail_count++;
        end
        if (rsp_word.entries_now !== want.entries_now) begin
          $error("entries_now: expected %0d, got %0d", want.entries_now, rsp_word.entries_now);
          fail_count++;
        end
        if (rsp_word.found_phone_hi !== want.found_phone_hi) begin
          $error("found_phone_hi: expected %h, got %h", want.found_phone_hi,
                 rsp_word.found_phone_hi);
          fail_count++;
        end
        if (rsp_word.found_phone_lo !== want.found_phone_lo) begin
          $error("found_phone_lo: expected %h, got %h", want.found_phone_lo,
                 rsp_word.found_phone_lo);
          fail_count++;
        end
        if (rsp_word.found_mail_w0 !== want.found_mail_w0) begin
          $error("found_mail_w0: expected %h, got %h", want.found_mail_w0,
                 rsp_word.found_mail_w0);
          fail_count++;
        end
        if (rsp_word.found_mail_w1 !== want.found_mail_w1) begin
          $error("found_mail_w1: expected %h, got %h", want.found_mail_w1,
                 rsp_word.found_mail_w1);
          fail_count++;
        end
        if (rsp_word.found_mail_w2 !== want.found_mail_w2) begin
          $error("found_mail_w2: expected %h, got %h", want.found_mail_w2,
                 rsp_word.found_mail_w2);
          fail_count++;
        end
        if (rsp_word.found_mail_w3 !== want.found_mail_w3) begin
          $error("found_mail_w3: expected %h, got %h", want.found_mail_w3,
                 rsp_word.found_mail_w3);
          fail_count++;
        end
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off when requested.
  always @(posedge clk) begin
    if (hold_off_cycles != 0) begin
      rsp_ready <= 1'b0;
      hold_off_cycles <= hold_off_cycles - 1;
    end else begin
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog: abort a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("Regression FAIL");
      $finish;
    end
  end

  // Directed rows: request plus, where obvious, the pinned response.
  typedef struct {
    krt_pkg::req_t rq;
    logic          pinned;
    krt_pkg::rsp_t rs;
  } stim_row_t;

  stim_row_t directed [$];

  function automatic krt_pkg::req_t mk_req(input krt_pkg::op_e op, input logic [127:0] k,
                                           input logic [127:0] ph, input logic [255:0] ml);
    krt_pkg::req_t rq;
    rq.opcode = op;
    {rq.key_hi, rq.key_lo} = k;
    {rq.phone_hi, rq.phone_lo} = ph;
    {rq.mail_w0, rq.mail_w1, rq.mail_w2, rq.mail_w3} = ml;
    return rq;
  endfunction

  function automatic krt_pkg::rsp_t mk_rsp(input krt_pkg::status_e st, input int unsigned n);
    krt_pkg::rsp_t rs;
    rs = '0;
    rs.status = st;
    rs.entries_now = n[7:0];
    return rs;
  endfunction

  initial begin
    stim_row_t     row;
    logic [127:0]  ones;
    krt_pkg::rsp_t none;
    int unsigned   sent;
    ones = '1;
    none = '0;
    fail_count = 0;
    rsp_count = 0;
    shadow_count = 0;
    cycle_count = 0;
    hold_off_cycles = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    foreach (status_hits[i]) status_hits[i] = 0;

    // Empty table: searches miss and delete leaves count at zero.
    directed.push_back('{mk_req(krt_pkg::OP_LOOKUP, '0, '0, '0), 1'b1,
                         mk_rsp(krt_pkg::ST_NOTFOUND, 0)});
    directed.push_back('{mk_req(krt_pkg::OP_DELETE, ones, '0, '0), 1'b1,
                         mk_rsp(krt_pkg::ST_NOTFOUND, 0)});
    directed.push_back('{mk_req(krt_pkg::OP_CHANGE, ones, ones, '1), 1'b1,
                         mk_rsp(krt_pkg::ST_NOTFOUND, 0)});
    // All-ones fields, then all-zero fields.
    directed.push_back('{mk_req(krt_pkg::OP_ADD, ones, ones, '1), 1'b1,
                         mk_rsp(krt_pkg::ST_ADDED, 1)});
    directed.push_back('{mk_req(krt_pkg::OP_ADD, '0, '0, '0), 1'b1,
                         mk_rsp(krt_pkg::ST_ADDED, 2)});
    directed.push_back('{mk_req(krt_pkg::OP_LOOKUP, ones, '0, '0), 1'b0, none});
    directed.push_back('{mk_req(krt_pkg::OP_LOOKUP, '0, ones, '1), 1'b0, none});
    // Trailing bytes after a terminator collapse to the same key.
    directed.push_back('{mk_req(krt_pkg::OP_ADD, {8'h42, 8'h00, 112'hdead_beef},
                                {8'h31, 120'h0}, {8'h61, 8'h0, 240'h1}), 1'b1,
                         mk_rsp(krt_pkg::ST_ADDED, 3)});
    directed.push_back('{mk_req(krt_pkg::OP_LOOKUP, {8'h42, 120'h0}, '0, '0), 1'b0, none});
    // Duplicates: the lowest index wins.
    directed.push_back('{mk_req(krt_pkg::OP_ADD, {8'h42, 120'h0}, {8'h32, 120'h0}, '1), 1'b1,
                         mk_rsp(krt_pkg::ST_ADDED, 4)});
    directed.push_back('{mk_req(krt_pkg::OP_CHANGE, {8'h42, 120'h0}, {16'h3939, 112'h0},
                                {8'h7a, 248'h0}), 1'b1, mk_rsp(krt_pkg::ST_UPDATED, 4)});
    directed.push_back('{mk_req(krt_pkg::OP_LOOKUP, {8'h42, 8'h01, 112'h0}, '0, '0), 1'b1,
                         mk_rsp(krt_pkg::ST_NOTFOUND, 4)});
    directed.push_back('{mk_req(krt_pkg::OP_LOOKUP, {8'h42, 120'h0}, '0, '0), 1'b0, none});
    directed.push_back('{mk_req(krt_pkg::OP_DELETE, {8'h42, 120'h0}, '0, '0), 1'b1,
                         mk_rsp(krt_pkg::ST_DELETED, 3)});
    directed.push_back('{mk_req(krt_pkg::OP_LOOKUP, {8'h42, 120'h0}, '0, '0), 1'b0, none});
    // Delete from the head shifts the rest down.
    directed.push_back('{mk_req(krt_pkg::OP_DELETE, ones, '0, '0), 1'b1,
                         mk_rsp(krt_pkg::ST_DELETED, 2)});
    directed.push_back('{mk_req(krt_pkg::OP_LOOKUP, '0, '0, '0), 1'b0, none});
    directed.push_back('{mk_req(krt_pkg::OP_DELETE, '0, '0, '0), 1'b1,
                         mk_rsp(krt_pkg::ST_DELETED, 1)});
    directed.push_back('{mk_req(krt_pkg::OP_DELETE, {8'h42, 120'h0}, '0, '0), 1'b1,
                         mk_rsp(krt_pkg::ST_DELETED, 0)});

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) begin
      row = directed[i];
      send_request(row.rq, row.pinned, row.rs);
    end
    drain_responses();

    // Fill the table to the brim while the receiver holds off, so the block
    // backs up and stalls its request side; then overflow it.
    hold_off_cycles = 600;
    for (int i = 0; i < TableDepth + 3; i++) begin
      row.rq = rand_request(60);
      row.rq.opcode = krt_pkg::OP_ADD;
      send_request(row.rq, 1'b0, none);
    end
    send_request(mk_req(krt_pkg::OP_ADD, ones, '0, '0), 1'b1,
                 mk_rsp(krt_pkg::ST_FULL, TableDepth));
    drain_responses();

    // Random phases: cycle the idle mix, small key pool to force hits.
    sent = 0;
    for (int phase = 0; phase < 8; phase++) begin
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 83; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 83; end
        default: begin send_idle_pct = 16; recv_stall_pct = 16; end
      endcase
      for (int i = 0; i < 95; i++) begin
        row.rq = rand_request((phase < 4) ? 6 : 26);
        // Bias toward adds when the table runs low, deletes when high.
        if (shadow_count < 8 && $urandom_range(1)) row.rq.opcode = krt_pkg::OP_ADD;
        if (shadow_count > 120 && $urandom_range(1)) row.rq.opcode = krt_pkg::OP_DELETE;
        send_request(row.rq, 1'b0, none);
        sent++;
      end
      // Sender pauses until every outstanding response is back.
      drain_responses();
    end

    send_idle_pct = 0;
    recv_stall_pct = 0;
    drain_responses();
    repeat (4 * (TableDepth + 2)) @(posedge clk);

    $display("checked %0d responses over %0d random requests and a full-table pass",
             rsp_count, sent);
    $display("added %0d full %0d found %0d missed %0d updated %0d deleted %0d",
             status_hits[0], status_hits[1], status_hits[2], status_hits[3],
             status_hits[4], status_hits[5]);
    if (fail_count == 0 && pending_rsp.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

>>> files.f
hw/rtl/krt_pkg.sv
hw/rtl/krt_cell.sv
hw/rtl/keyed_record_table_top.sv
bench/keyed_record_table_top_tb.sv
